// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int MAX_RESOURCES = 8;
	localparam int AMOUNT_BITS   = 8;

	// Field widths of the request and result ports.
	localparam int KIND_BITS   = 3;
	localparam int PROC_BITS   = 4;
	localparam int RES_BITS    = 3;
	localparam int STATUS_BITS = 3;
	localparam int PCNT_BITS   = 5;
	localparam int RCNT_BITS   = 4;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;

	// Work holds the available amount plus every allocation, one of which may be raised by a request.
	localparam int WORK_BITS  = AMOUNT_BITS + $clog2(MAX_PROCESSES) + 1;
	localparam int ELEM_ABITS = PROC_BITS + RES_BITS;
	localparam int ELEM_DEPTH = 2 ** ELEM_ABITS;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PROCESS_COUNT  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RESOURCE_COUNT = 1'b1;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_SET_AVAIL = 3'd0,
		KIND_SET_NEED  = 3'd1,
		KIND_SET_ALLOC = 3'd2,
		KIND_SET_REQ   = 3'd3,
		KIND_CHECK     = 3'd4,
		KIND_EVAL      = 3'd5
	} kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_ORDER      = 3'd0,
		ST_DEAD_PROC  = 3'd1,
		ST_SAFE       = 3'd2,
		ST_DEADLOCK   = 3'd3,
		ST_OVER_NEED  = 3'd4,
		ST_OVER_AVAIL = 3'd5
	} status_t;

	typedef struct packed {
		logic    write;
		logic    load_eval;
		logic    init_check;
		logic    init_eval;
		logic    p_clr;
		logic    p_inc;
		logic    r_clr;
		logic    r_inc;
		logic    fits_set;
		logic    need_cmp;
		logic    alloc_add;
		logic    finish;
		logic    emit;
		status_t emit_status;
		logic    emit_pid;
		logic    emit_last;
	} cmd_t;

	typedef struct packed {
		logic p_end;
		logic r_end;
		logic round_go;
		logic all_done;
		logic fin_p;
		logic fits;
		logic tp_out;
		logic req_gt_need;
		logic req_gt_avail;
	} sts_t;

endpackage

// ===== rtl/bsc_ram.sv =====
module bsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bsc_datapath.sv =====
module bsc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsc_pkg::cmd_t                       cmd,
	output bsc_pkg::sts_t                       sts,
	input  logic [bsc_pkg::KIND_BITS-1:0]       kind,
	input  logic [bsc_pkg::PROC_BITS-1:0]       process_index,
	input  logic [bsc_pkg::RES_BITS-1:0]        resource_index,
	input  logic [bsc_pkg::AMOUNT_BITS-1:0]     amount,
	input  logic                                cfg_we,
	input  logic [bsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bsc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic                                result_strobe,
	output logic [bsc_pkg::STATUS_BITS-1:0]     status,
	output logic [bsc_pkg::PROC_BITS-1:0]       process_id,
	output logic                                last
);

	localparam int AB = bsc_pkg::AMOUNT_BITS;
	localparam int WB = bsc_pkg::WORK_BITS;
	localparam int NR = bsc_pkg::MAX_RESOURCES;
	localparam int NP = bsc_pkg::MAX_PROCESSES;
	localparam int PB = bsc_pkg::PROC_BITS;
	localparam int RB = bsc_pkg::RES_BITS;
	localparam int PCB = bsc_pkg::PCNT_BITS;
	localparam int RCB = bsc_pkg::RCNT_BITS;
	localparam int EA = bsc_pkg::ELEM_ABITS;
	localparam int ED = bsc_pkg::ELEM_DEPTH;

	logic [PCB-1:0] pcount_q;
	logic [RCB-1:0] rcount_q;
	logic [PCB-1:0] np;
	logic [RCB-1:0] nr;

	logic [AB-1:0] avail_q [NR];
	logic [AB-1:0] req_q [NR];
	logic [WB-1:0] work_q [NR];
	logic [NP-1:0] finished_q;
	logic [ED-1:0] need_vld_q, alloc_vld_q;
	logic          need_rvld_q, alloc_rvld_q;

	logic [PCB-1:0] p_q, done_q, round_q;
	logic [RCB-1:0] r_q;
	logic [PB-1:0]  tp_q;
	logic           tp_vld_q;
	logic           fits_q;

	logic          need_we, alloc_we;
	logic [EA-1:0] waddr, raddr;
	logic [AB-1:0] need_raw, alloc_raw, need_rd, alloc_rd;
	logic [AB-1:0] need_eff;
	logic [AB:0]   alloc_eff;
	logic [RB-1:0] ri;
	logic          row_tp;

	assign np = (pcount_q > PCB'(NP)) ? PCB'(NP) : pcount_q;
	assign nr = (rcount_q > RCB'(NR)) ? RCB'(NR) : rcount_q;

	assign waddr = {process_index, resource_index};
	assign raddr = {p_q[PB-1:0], r_q[RB-1:0]};
	assign ri    = r_q[RB-1:0];

	always_comb begin
		need_we  = 1'b0;
		alloc_we = 1'b0;
		if (cmd.write) begin
			case (bsc_pkg::kind_t'(kind))
				bsc_pkg::KIND_SET_NEED:  need_we  = 1'b1;
				bsc_pkg::KIND_SET_ALLOC: alloc_we = 1'b1;
				default: ;
			endcase
		end
	end

	bsc_ram #(.WIDTH(AB), .DEPTH(ED)) u_need_ram (
		.clk   (clk),
		.we    (need_we),
		.waddr (waddr),
		.wdata (amount),
		.raddr (raddr),
		.rdata (need_raw)
	);

	bsc_ram #(.WIDTH(AB), .DEPTH(ED)) u_alloc_ram (
		.clk   (clk),
		.we    (alloc_we),
		.waddr (waddr),
		.wdata (amount),
		.raddr (raddr),
		.rdata (alloc_raw)
	);

	// Entries never written read as zero.
	assign need_rd  = need_rvld_q ? need_raw : '0;
	assign alloc_rd = alloc_rvld_q ? alloc_raw : '0;

	// The row under evaluation is seen with the request already granted.
	assign row_tp    = tp_vld_q && (p_q == PCB'(tp_q));
	assign need_eff  = row_tp ? need_rd - req_q[ri] : need_rd;
	assign alloc_eff = row_tp ? {1'b0, alloc_rd} + {1'b0, req_q[ri]} : {1'b0, alloc_rd};

	assign sts.p_end        = p_q >= np;
	assign sts.r_end        = r_q >= nr;
	assign sts.round_go     = (round_q < np) && (done_q < np);
	assign sts.all_done     = done_q == np;
	assign sts.fin_p        = finished_q[p_q[PB-1:0]];
	assign sts.fits         = fits_q;
	assign sts.tp_out       = PCB'(tp_q) >= np;
	assign sts.req_gt_need  = req_q[ri] > need_rd;
	assign sts.req_gt_avail = req_q[ri] > avail_q[ri];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q     <= PCB'(1);
			rcount_q     <= RCB'(1);
			need_vld_q   <= '0;
			alloc_vld_q  <= '0;
			need_rvld_q  <= 1'b0;
			alloc_rvld_q <= 1'b0;
			finished_q   <= '0;
			for (int i = 0; i < NR; i++) begin
				avail_q[i] <= '0;
				req_q[i]   <= '0;
				work_q[i]  <= '0;
			end
			p_q           <= '0;
			r_q           <= '0;
			done_q        <= '0;
			round_q       <= '0;
			tp_q          <= '0;
			tp_vld_q      <= 1'b0;
			fits_q        <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			need_rvld_q  <= need_vld_q[raddr];
			alloc_rvld_q <= alloc_vld_q[raddr];

			if (cfg_we) begin
				case (cfg_index)
					bsc_pkg::CFG_PROCESS_COUNT:  pcount_q <= cfg_data[PCB-1:0];
					bsc_pkg::CFG_RESOURCE_COUNT: rcount_q <= cfg_data[RCB-1:0];
					default: ;
				endcase
			end

			if (cmd.write) begin
				case (bsc_pkg::kind_t'(kind))
					bsc_pkg::KIND_SET_AVAIL: avail_q[resource_index] <= amount;
					bsc_pkg::KIND_SET_REQ:   req_q[resource_index]   <= amount;
					bsc_pkg::KIND_SET_NEED:  need_vld_q[waddr]       <= 1'b1;
					bsc_pkg::KIND_SET_ALLOC: alloc_vld_q[waddr]      <= 1'b1;
					default: ;
				endcase
			end

			if (cmd.load_eval) begin
				tp_q     <= process_index;
				p_q      <= PCB'(process_index);
				r_q      <= '0;
				tp_vld_q <= 1'b1;
			end

			if (cmd.init_check || cmd.init_eval) begin
				finished_q <= '0;
				done_q     <= '0;
				round_q    <= '0;
				for (int i = 0; i < NR; i++) begin
					if (cmd.init_eval && (RCB'(i) < nr)) begin
						work_q[i] <= WB'(avail_q[i] - req_q[i]);
					end else begin
						work_q[i] <= WB'(avail_q[i]);
					end
				end
			end
			if (cmd.init_check) begin
				tp_vld_q <= 1'b0;
			end

			if (cmd.p_clr) begin
				p_q <= '0;
			end else if (cmd.p_inc) begin
				p_q <= p_q + 1'b1;
			end
			if (cmd.r_clr) begin
				r_q <= '0;
			end else if (cmd.r_inc) begin
				r_q <= r_q + 1'b1;
			end

			if (cmd.fits_set) begin
				fits_q <= 1'b1;
			end else if (cmd.need_cmp && (WB'(need_eff) > work_q[ri])) begin
				fits_q <= 1'b0;
			end

			if (cmd.alloc_add) begin
				work_q[ri] <= work_q[ri] + WB'(alloc_eff);
			end

			if (cmd.finish) begin
				finished_q[p_q[PB-1:0]] <= 1'b1;
				done_q  <= done_q + 1'b1;
				round_q <= round_q + 1'b1;
			end

			result_strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status     <= cmd.emit_status;
			process_id <= cmd.emit_pid ? p_q[PB-1:0] : '0;
			last       <= cmd.emit_last;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done_q <= PCB'(NP))
		else $error("finished process count exceeds the process limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> $countones(finished_q) == $past($countones(finished_q)) + 1)
		else $error("finishing a process did not set exactly one new flag");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |=> result_strobe)
		else $error("an emitted result did not raise the strobe");

endmodule

// ===== rtl/bsc_ctrl.sv =====
module bsc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bsc_pkg::KIND_BITS-1:0] kind,
	input  bsc_pkg::sts_t                 sts,
	output bsc_pkg::cmd_t                 cmd,
	output logic                          busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EV0,
		S_QRD,
		S_QCMP,
		S_AVCHK,
		S_ROUND,
		S_PSCAN,
		S_NRD,
		S_NCMP,
		S_ARD,
		S_AADD,
		S_VERDICT,
		S_DEAD
	} state_t;

	state_t state_q, state_nxt;

	assign busy = state_q != S_IDLE;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (bsc_pkg::kind_t'(kind))
						bsc_pkg::KIND_SET_AVAIL, bsc_pkg::KIND_SET_NEED,
						bsc_pkg::KIND_SET_ALLOC, bsc_pkg::KIND_SET_REQ: begin
							cmd.write = 1'b1;
						end
						bsc_pkg::KIND_CHECK: begin
							cmd.init_check = 1'b1;
							state_nxt      = S_ROUND;
						end
						bsc_pkg::KIND_EVAL: begin
							cmd.load_eval = 1'b1;
							state_nxt     = S_EV0;
						end
						default: ;
					endcase
				end
			end
			S_EV0: begin
				if (sts.tp_out) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = bsc_pkg::ST_OVER_NEED;
					cmd.emit_last   = 1'b1;
					state_nxt       = S_IDLE;
				end else begin
					cmd.r_clr = 1'b1;
					state_nxt = S_QRD;
				end
			end
			S_QRD: begin
				if (sts.r_end) begin
					cmd.r_clr = 1'b1;
					state_nxt = S_AVCHK;
				end else begin
					state_nxt = S_QCMP;
				end
			end
			S_QCMP: begin
				if (sts.req_gt_need) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = bsc_pkg::ST_OVER_NEED;
					cmd.emit_last   = 1'b1;
					state_nxt       = S_IDLE;
				end else begin
					cmd.r_inc = 1'b1;
					state_nxt = S_QRD;
				end
			end
			S_AVCHK: begin
				if (sts.r_end) begin
					cmd.init_eval = 1'b1;
					state_nxt     = S_ROUND;
				end else if (sts.req_gt_avail) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = bsc_pkg::ST_OVER_AVAIL;
					cmd.emit_last   = 1'b1;
					state_nxt       = S_IDLE;
				end else begin
					cmd.r_inc = 1'b1;
				end
			end
			S_ROUND: begin
				if (sts.round_go) begin
					cmd.p_clr = 1'b1;
					state_nxt = S_PSCAN;
				end else begin
					state_nxt = S_VERDICT;
				end
			end
			S_PSCAN: begin
				// A round that finds no process leaves nothing for later rounds.
				if (sts.p_end) begin
					state_nxt = S_VERDICT;
				end else if (sts.fin_p) begin
					cmd.p_inc = 1'b1;
				end else begin
					cmd.r_clr    = 1'b1;
					cmd.fits_set = 1'b1;
					state_nxt    = S_NRD;
				end
			end
			S_NRD: begin
				if (sts.r_end) begin
					if (sts.fits) begin
						cmd.r_clr = 1'b1;
						state_nxt = S_ARD;
					end else begin
						cmd.p_inc = 1'b1;
						state_nxt = S_PSCAN;
					end
				end else begin
					state_nxt = S_NCMP;
				end
			end
			S_NCMP: begin
				cmd.need_cmp = 1'b1;
				cmd.r_inc    = 1'b1;
				state_nxt    = S_NRD;
			end
			S_ARD: begin
				if (sts.r_end) begin
					cmd.finish      = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_status = bsc_pkg::ST_ORDER;
					cmd.emit_pid    = 1'b1;
					state_nxt       = S_ROUND;
				end else begin
					state_nxt = S_AADD;
				end
			end
			S_AADD: begin
				cmd.alloc_add = 1'b1;
				cmd.r_inc     = 1'b1;
				state_nxt     = S_ARD;
			end
			S_VERDICT: begin
				if (sts.all_done) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = bsc_pkg::ST_SAFE;
					cmd.emit_last   = 1'b1;
					state_nxt       = S_IDLE;
				end else begin
					cmd.p_clr = 1'b1;
					state_nxt = S_DEAD;
				end
			end
			S_DEAD: begin
				if (sts.p_end) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = bsc_pkg::ST_DEADLOCK;
					cmd.emit_last   = 1'b1;
					state_nxt       = S_IDLE;
				end else begin
					if (!sts.fin_p) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = bsc_pkg::ST_DEAD_PROC;
						cmd.emit_pid    = 1'b1;
					end
					cmd.p_inc = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.emit_last |=> state_q == S_IDLE)
		else $error("controller kept working after the final result");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cmd.emit)
		else $error("result emitted while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		start && state_q == S_IDLE && kind <= bsc_pkg::KIND_BITS'(bsc_pkg::KIND_SET_REQ)
		|=> state_q == S_IDLE)
		else $error("element write left the controller busy");

endmodule

// ===== rtl/bankers_safety_check_top.sv =====
// Channel   | Signals                                            | Handshake
// ----------+----------------------------------------------------+-----------------------------
// request   | kind, process_index, resource_index, amount        | start high while busy low
// result    | status, process_id, last                           | result_strobe, one cycle
// config    | cfg_index, cfg_data                                | cfg_we, taken at once
//
// Element writes leave the block idle. A safety check or a
// request evaluation walks the need and allocation memories one element at a
// time, through their registered read. One round scans up to np processes
// and adds the allocation row of the first one that fits to the work vector;
// a search repeats rounds until all np processes have finished or a round
// finds none that fits, for np processes and nr resources.
// Reset clears the per-element valid flags, so unwritten elements read as zero;
// no clearing pass is needed.
// Results are presented for exactly one cycle and cannot be held off.

module bankers_safety_check_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bsc_pkg::KIND_BITS-1:0]       kind,
	input  logic [bsc_pkg::PROC_BITS-1:0]       process_index,
	input  logic [bsc_pkg::RES_BITS-1:0]        resource_index,
	input  logic [bsc_pkg::AMOUNT_BITS-1:0]     amount,
	input  logic                                cfg_we,
	input  logic [bsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bsc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic                                result_strobe,
	output logic [bsc_pkg::STATUS_BITS-1:0]     status,
	output logic [bsc_pkg::PROC_BITS-1:0]       process_id,
	output logic                                last
);

	// The controller sequences the search; the datapath holds every store,
	// the loop counters and the result register.
	bsc_pkg::cmd_t cmd;
	bsc_pkg::sts_t sts;

	bsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bsc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.process_index  (process_index),
		.resource_index (resource_index),
		.amount         (amount),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_strobe  (result_strobe),
		.status         (status),
		.process_id     (process_id),
		.last           (last)
	);

endmodule
